@@ sv/integer_square_root_exact_unit_defines.svh @@
// Assertion helpers used by the square root core.
`ifndef INTEGER_SQUARE_ROOT_EXACT_UNIT_DEFINES_SVH
`define INTEGER_SQUARE_ROOT_EXACT_UNIT_DEFINES_SVH

// Plain property checked at every clock edge outside reset.
`define ISQE_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next cycle.
`define ISQE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/isqe_pkg.sv @@
package isqe_pkg;

	localparam int DATA_WIDTH = 64;
	localparam int VALUE_W    = 64;
	localparam int ROOT_W     = 32;
	localparam int STATUS_W   = 2;

	// One root bit per step, two operand bits consumed per step.
	localparam int STEPS = (DATA_WIDTH + 1) / 2;
	localparam int OP_W  = 2 * STEPS;
	localparam int REM_W = STEPS + 2;
	localparam int CNT_W = $clog2(STEPS);

	localparam logic [STATUS_W-1:0] ST_EXACT      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_SQUARE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NEGATIVE   = 2'd2;

	typedef struct packed {
		logic [ROOT_W-1:0]   root;
		logic [STATUS_W-1:0] status;
	} res_t;

endpackage

@@ sv/isqe_core.sv @@
`include "integer_square_root_exact_unit_defines.svh"

module isqe_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [isqe_pkg::VALUE_W-1:0] in_value,
	output logic                        res_valid,
	input  logic                        res_ready,
	output isqe_pkg::res_t              res
);

	localparam int OP_W  = isqe_pkg::OP_W;
	localparam int REM_W = isqe_pkg::REM_W;
	localparam int STEPS = isqe_pkg::STEPS;
	localparam int CNT_W = isqe_pkg::CNT_W;
	localparam int DW    = isqe_pkg::DATA_WIDTH;
	localparam int ROOT_W = isqe_pkg::ROOT_W;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RUN  = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [OP_W-1:0]  op_q;
	logic [REM_W-1:0] rem_q;
	logic [STEPS-1:0] root_q;
	logic             neg_q;

	logic             accept;
	logic [REM_W-1:0] shifted;
	logic [REM_W-1:0] trial;
	logic [REM_W:0]   diff;
	logic             exact;

	assign in_ready  = (state_q == S_IDLE) || ((state_q == S_DONE) && res_ready);
	assign accept    = in_valid && in_ready;
	assign res_valid = (state_q == S_DONE);

	// Bring down the next two operand bits and try the odd trial value 4*root+1.
	assign shifted = {rem_q[REM_W-3:0], op_q[OP_W-1 -: 2]};
	assign trial   = {root_q, 2'b01};
	assign diff    = {1'b0, shifted} - {1'b0, trial};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			neg_q   <= 1'b0;
		end else if (accept) begin
			neg_q   <= in_value[DW-1];
			cnt_q   <= CNT_W'(STEPS - 1);
			state_q <= in_value[DW-1] ? S_DONE : S_RUN;
		end else begin
			unique case (state_q)
				S_IDLE: begin
				end
				S_RUN: begin
					if (cnt_q == '0) begin
						state_q <= S_DONE;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= OP_W'(in_value[DW-1:0]);
			rem_q  <= '0;
			root_q <= '0;
		end else if (state_q == S_RUN) begin
			op_q <= {op_q[OP_W-3:0], 2'b00};
			if (!diff[REM_W]) begin
				rem_q  <= diff[REM_W-1:0];
				root_q <= {root_q[STEPS-2:0], 1'b1};
			end else begin
				rem_q  <= shifted;
				root_q <= {root_q[STEPS-2:0], 1'b0};
			end
		end
	end

	// A zero remainder after the last step means the input was a perfect square.
	assign exact = (rem_q == '0);

	always_comb begin
		if (neg_q) begin
			res.status = isqe_pkg::ST_NEGATIVE;
		end else if (exact) begin
			res.status = isqe_pkg::ST_EXACT;
		end else begin
			res.status = isqe_pkg::ST_NOT_SQUARE;
		end
		res.root = (!neg_q && exact) ? ROOT_W'(root_q) : '0;
	end

	`ISQE_ASSERT_NEXT(a_run_ends, clk, arst_n, (state_q == S_RUN) && (cnt_q == '0) && !accept,
		state_q == S_DONE, "last root step did not finish the item")
	`ISQE_ASSERT(a_rem_bound, clk, arst_n,
		(state_q == S_IDLE) || (rem_q <= REM_W'({root_q, 1'b0})),
		"remainder exceeds twice the partial root")
	`ISQE_ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, state_q != S_IDLE,
		"accepted item was dropped")
	`ISQE_ASSERT(a_neg_root_zero, clk, arst_n,
		!(res_valid && neg_q) || ((res.root == '0) && (res.status == isqe_pkg::ST_NEGATIVE)),
		"negative input produced a nonzero root")

endmodule

@@ sv/isqe_out.sv @@
module isqe_out (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           res_valid,
	output logic           res_ready,
	input  isqe_pkg::res_t res,
	output logic           out_valid,
	input  logic           out_ready,
	output isqe_pkg::res_t out_res
);

	logic           valid_q;
	isqe_pkg::res_t data_q;

	assign res_ready = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			data_q <= res;
		end
	end

endmodule

@@ sv/integer_square_root_exact_unit.sv @@
// Exact integer square root of a signed 64-bit operand.
// Input: one transfer on the s_ side carries the operand in s_tdata. Negative
// operands return status negative with a zero root at once.
// Otherwise a restoring square root produces one root bit per cycle, taking two
// operand bits per cycle from a shift register. The result then waits in the
// core, where its remainder is checked for zero, until the output takes it.
// Output: m_tdata carries the root (zero unless the operand is a perfect
// square), m_tuser carries the status: exact, not a square, or negative.
// One item is in the core at a time: a new operand is taken only when the
// core is idle or in the cycle its predecessor moves to the output register.
// Reset clears all valid and state flags; no result is presented afterward.
// When the receiver stalls, the output register holds its result, the core
// keeps one finished result behind it, and s_tready stays low until room frees.
module integer_square_root_exact_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // [63:0] value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [31:0] root
	output logic [1:0]  m_tuser   // [1:0] status
);

	logic           res_valid;
	logic           res_ready;
	isqe_pkg::res_t res;
	isqe_pkg::res_t out_res;

	isqe_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_value  (s_tdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	isqe_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = out_res.root;
	assign m_tuser = out_res.status;

endmodule
